/* rtl/rpd_pkg.sv */
package rpd_pkg;

    localparam int COUNT_BITS = 32;
    localparam int TOTAL_BITS = 32;

    localparam logic [7:0] MARK_SAME = 8'h00;
    localparam logic [7:0] MARK_ONE  = 8'hC0;
    localparam logic [7:0] MARK_MANY = 8'hFF;

    localparam logic [14:0] WEIGHT_RED   = 15'd22937;
    localparam logic [15:0] WEIGHT_GREEN = 16'd36044;
    localparam logic [12:0] WEIGHT_BLUE  = 13'd6553;
    localparam int          GREY_SHIFT   = 18;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [1:0]            chan_n_t;

    typedef struct packed {
        logic [7:0] first_red;
        logic [7:0] first_green;
        logic [7:0] first_blue;
        logic [7:0] second_red;
        logic [7:0] second_green;
        logic [7:0] second_blue;
        logic       unpaired;
        logic       restart;
    } pair_t;

    typedef struct packed {
        logic [7:0]            out_red;
        logic [7:0]            out_green;
        logic [7:0]            out_blue;
        logic [TOTAL_BITS-1:0] match_total;
        logic [TOTAL_BITS-1:0] one_off_total;
        logic [TOTAL_BITS-1:0] many_off_total;
        logic                  any_differs;
    } diff_t;

    typedef struct packed {
        chan_n_t match_n;
        chan_n_t one_off_n;
        chan_n_t many_off_n;
        logic    differs;
    } tally_t;

    function automatic count_t sat_add(count_t c, chan_n_t n);
        logic [COUNT_BITS:0] s;
        s = {1'b0, c} + (COUNT_BITS + 1)'(n);
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [TOTAL_BITS-1:0] clamp_total(count_t c);
        logic [63:0] w;
        w = 64'(c);
        return (w > 64'hFFFF_FFFF) ? '1 : w[TOTAL_BITS-1:0];
    endfunction

endpackage

/* rtl/rpd_classify.sv */
module rpd_classify (
    input  rpd_pkg::pair_t  pair,
    output logic [7:0]      out_red,
    output logic [7:0]      out_green,
    output logic [7:0]      out_blue,
    output rpd_pkg::tally_t tally
);

    logic [7:0] a [3];
    logic [7:0] b [3];
    logic [7:0] d [3];
    logic [7:0] mark [3];
    logic       same [3];
    logic       one [3];
    logic [23:0] grey_sum;
    logic [7:0]  grey;
    logic        all_same;

    assign a[0] = pair.first_red;
    assign a[1] = pair.first_green;
    assign a[2] = pair.first_blue;
    assign b[0] = pair.second_red;
    assign b[1] = pair.second_green;
    assign b[2] = pair.second_blue;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            d[ch]    = (a[ch] > b[ch]) ? (a[ch] - b[ch]) : (b[ch] - a[ch]);
            same[ch] = (d[ch] == 8'd0);
            one[ch]  = (d[ch] == 8'd1);
            mark[ch] = same[ch] ? rpd_pkg::MARK_SAME
                     : (one[ch] ? rpd_pkg::MARK_ONE : rpd_pkg::MARK_MANY);
        end
    end

    assign all_same = same[0] && same[1] && same[2];

    // weighted luma (weights 0.35, 0.55, 0.10 of 65536), then quartered
    assign grey_sum = 24'(rpd_pkg::WEIGHT_RED) * 24'(a[0])
                    + 24'(rpd_pkg::WEIGHT_GREEN) * 24'(a[1])
                    + 24'(rpd_pkg::WEIGHT_BLUE) * 24'(a[2]);
    assign grey     = 8'(grey_sum >> rpd_pkg::GREY_SHIFT);

    always_comb
    begin
        if (pair.unpaired)
        begin
            out_red          = '0;
            out_green        = '0;
            out_blue         = '0;
            tally.match_n    = 2'd0;
            tally.one_off_n  = 2'd0;
            tally.many_off_n = 2'd3;
            tally.differs    = 1'b1;
        end
        else
        begin
            out_red          = all_same ? grey : mark[0];
            out_green        = all_same ? grey : mark[1];
            out_blue         = all_same ? grey : mark[2];
            tally.match_n    = 2'(same[0]) + 2'(same[1]) + 2'(same[2]);
            tally.one_off_n  = 2'(one[0]) + 2'(one[1]) + 2'(one[2]);
            tally.many_off_n = 2'(!same[0] && !one[0]) + 2'(!same[1] && !one[1])
                             + 2'(!same[2] && !one[2]);
            tally.differs    = !all_same;
        end
    end

endmodule

/* rtl/rpd_counters.sv */
module rpd_counters (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           restart,
    input  rpd_pkg::tally_t                tally,
    output logic [rpd_pkg::TOTAL_BITS-1:0] match_total,
    output logic [rpd_pkg::TOTAL_BITS-1:0] one_off_total,
    output logic [rpd_pkg::TOTAL_BITS-1:0] many_off_total,
    output logic                           any_differs
);

    rpd_pkg::count_t match_reg, match_next;
    rpd_pkg::count_t one_off_reg, one_off_next;
    rpd_pkg::count_t many_off_reg, many_off_next;
    logic            differs_reg, differs_next;

    always_comb
    begin
        match_next    = rpd_pkg::sat_add(restart ? '0 : match_reg, tally.match_n);
        one_off_next  = rpd_pkg::sat_add(restart ? '0 : one_off_reg, tally.one_off_n);
        many_off_next = rpd_pkg::sat_add(restart ? '0 : many_off_reg, tally.many_off_n);
        differs_next  = (!restart && differs_reg) || tally.differs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg    <= '0;
            one_off_reg  <= '0;
            many_off_reg <= '0;
            differs_reg  <= 1'b0;
        end
        else if (advance)
        begin
            match_reg    <= match_next;
            one_off_reg  <= one_off_next;
            many_off_reg <= many_off_next;
            differs_reg  <= differs_next;
        end
    end

    assign match_total    = rpd_pkg::clamp_total(match_next);
    assign one_off_total  = rpd_pkg::clamp_total(one_off_next);
    assign many_off_total = rpd_pkg::clamp_total(many_off_next);
    assign any_differs    = differs_next;

endmodule

/* rtl/rgb_pixel_diff_engine.sv */
// an accepted pair request passes the input register, then the result register, before diff request valid
// throughput: one pixel pair per cycle while diff_ready does not stall, input register then result register
// stalls on diff_ready back up through both registers, no bubbles inserted
// reset: rst_n asynchronous active low clears valids, counters and differs flag
module rgb_pixel_diff_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pair_valid,
    output logic           pair_ready,
    input  rpd_pkg::pair_t pair,
    output logic           diff_valid,
    input  logic           diff_ready,
    output rpd_pkg::diff_t diff
);

    logic            s1_valid_reg;
    rpd_pkg::pair_t  s1_data_reg;
    logic            res_valid_reg;
    rpd_pkg::diff_t  res_data_reg;
    rpd_pkg::diff_t  res_data_next;
    rpd_pkg::tally_t tally;
    logic            advance;

    assign advance    = s1_valid_reg && (!res_valid_reg || diff_ready);
    assign pair_ready = !s1_valid_reg || advance;

    rpd_classify u_classify (
        .pair      (s1_data_reg),
        .out_red   (res_data_next.out_red),
        .out_green (res_data_next.out_green),
        .out_blue  (res_data_next.out_blue),
        .tally     (tally)
    );

    rpd_counters u_counters (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .restart        (s1_data_reg.restart),
        .tally          (tally),
        .match_total    (res_data_next.match_total),
        .one_off_total  (res_data_next.one_off_total),
        .many_off_total (res_data_next.many_off_total),
        .any_differs    (res_data_next.any_differs)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pair_ready)
            begin
                s1_valid_reg <= pair_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (diff_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_ready && pair_valid)
        begin
            s1_data_reg <= pair;
        end
        if (advance)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign diff_valid = res_valid_reg;
    assign diff       = res_data_reg;

endmodule

/* rtl/rpd_checker.sv */
module rpd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           pair_valid,
    input logic           pair_ready,
    input rpd_pkg::pair_t pair,
    input logic           diff_valid,
    input logic           diff_ready,
    input rpd_pkg::diff_t diff
);

    logic mixed;

    assign mixed = (diff.out_red != diff.out_green) || (diff.out_green != diff.out_blue);

    a_pair_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && !pair_ready |=> pair_valid && $stable(pair))
        else $error("pair request dropped or changed while stalled");

    a_diff_hold: assert property (@(posedge clk) disable iff (!rst_n)
        diff_valid && !diff_ready |=> diff_valid && $stable(diff))
        else $error("diff request dropped or changed while stalled");

    a_no_differs_clean: assert property (@(posedge clk) disable iff (!rst_n)
        diff_valid && !diff.any_differs |->
            diff.one_off_total == '0 && diff.many_off_total == '0)
        else $error("mismatch counted without differs flag");

    a_mark_codes: assert property (@(posedge clk) disable iff (!rst_n)
        diff_valid && mixed |->
            diff.any_differs
            && (diff.out_red == rpd_pkg::MARK_SAME || diff.out_red == rpd_pkg::MARK_ONE
                || diff.out_red == rpd_pkg::MARK_MANY)
            && (diff.out_blue == rpd_pkg::MARK_SAME || diff.out_blue == rpd_pkg::MARK_ONE
                || diff.out_blue == rpd_pkg::MARK_MANY))
        else $error("non-grey output carries an unknown mark");

    a_grey_range: assert property (@(posedge clk) disable iff (!rst_n)
        diff_valid && !diff.any_differs |-> diff.out_red < 8'd64 && !mixed)
        else $error("grey output out of range");

endmodule

bind rgb_pixel_diff_engine rpd_checker u_rpd_checker (.*);
